// File: sv/gef_pkg.sv
// Shared types and constants of the glowing edge filter.
package gef_pkg;
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxHeightDef = 4096;
  localparam int unsigned FwW = 12;
  localparam int unsigned FhW = 13;
  localparam int unsigned SwW = 4;
  localparam int unsigned CfgW = 13;
  localparam int unsigned PixW = 24;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegWeight = 2'd2;

  // One result job: window columns and rows already picked.
  typedef struct packed {
    logic [PixW-1:0] tl, tc, tr, ml, mr, bl, bc, br;
    logic            run_end;
    logic            frame_end;
  } job_t;
endpackage

// File: sv/gef_front.sv
// Front part: line stores, window, position counters and job issue.
module gef_front #(
  parameter int unsigned MaxWidth  = gef_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gef_pkg::MaxHeightDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [gef_pkg::PixW-1:0] pix_i,
  input  logic [gef_pkg::FwW-1:0]  frame_width_i,
  input  logic [gef_pkg::FhW-1:0]  frame_height_i,
  output logic                     job_valid_o,
  output gef_pkg::job_t            job_o,
  input  logic                     q_room_i
);
  import gef_pkg::*;
  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight);
  localparam int unsigned WW = $clog2(MaxWidth + 1) > FwW ? $clog2(MaxWidth + 1) : FwW;
  localparam int unsigned HW = $clog2(MaxHeight + 1) > FhW ? $clog2(MaxHeight + 1) : FhW;

  logic [PixW-1:0] up_mem [MaxWidth];
  logic [PixW-1:0] mid_mem [MaxWidth];
  logic [PixW-1:0] up_rd, mid_rd;

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW-1:0] fw_x;
  logic [HW-1:0] fh_x;
  logic          take;

  // stage 1 registers: position flags of accepted pixel
  logic            s1_v_q;
  logic [PixW-1:0] s1_pix_q;
  logic            s1_r1_q, s1_c1_q, s1_rge1_q, s1_cge1_q, s1_end_q, s1_last_q;

  logic [PixW-1:0] w_q [9];
  logic [1:0]      sub_q;
  logic            busy;
  logic            endrow, lastrow;

  assign fw_x = WW'(frame_width_i);
  assign fh_x = HW'(frame_height_i);
  always_comb begin
    w_eff = fw_x < WW'(2) ? WW'(2) : (fw_x > WW'(MaxWidth) ? WW'(MaxWidth) : fw_x);
    h_eff = fh_x < HW'(2) ? HW'(2) : (fh_x > HW'(MaxHeight) ? HW'(MaxHeight) : fh_x);
  end
  assign endrow  = WW'(col_q) >= w_eff - WW'(1);
  assign lastrow = HW'(row_q) >= h_eff - HW'(1);

  // up to four jobs per pixel; sub_q steps through them
  logic       j0, j1, j2, j3;
  assign j0 = s1_v_q && s1_rge1_q && s1_cge1_q;
  assign j1 = j0 && s1_last_q;
  assign j2 = s1_v_q && s1_rge1_q && s1_end_q;
  assign j3 = j2 && s1_last_q;

  logic [3:0] pend;
  always_comb begin
    pend = {j3, j2, j1, j0};
    for (int i = 0; i < 4; i++) if (i < int'(sub_q)) pend[i] = 1'b0;
  end
  logic [1:0] cur;
  logic       any;
  always_comb begin
    cur = 2'd0;
    any = |pend;
    for (int i = 3; i >= 0; i--) if (pend[i]) cur = 2'(i);
  end
  logic more;
  always_comb begin
    more = 1'b0;
    for (int i = 0; i < 4; i++) if (i > int'(cur) && pend[i]) more = 1'b1;
  end
  assign busy    = any && (more || !q_room_i);
  assign stall_o = busy;
  assign take    = valid_i && !stall_o;

  always_ff @(posedge clk_i) begin
    if (take) begin
      up_rd <= up_mem[col_q];
      mid_rd <= mid_mem[col_q];
      up_mem[col_q] <= mid_mem[col_q];
      mid_mem[col_q] <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s1_v_q <= 1'b0;
      sub_q <= 2'd0;
      for (int i = 0; i < 9; i++) w_q[i] <= '0;
    end else begin
      if (any && q_room_i) sub_q <= more ? cur + 2'd1 : 2'd0;
      if (!busy) s1_v_q <= take;
      if (take) begin
        if (endrow) begin
          col_q <= '0;
          row_q <= lastrow ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (!busy && s1_v_q) begin
        w_q[0] <= w_q[1]; w_q[1] <= w_q[2]; w_q[2] <= up_rd;
        w_q[3] <= w_q[4]; w_q[4] <= w_q[5]; w_q[5] <= mid_rd;
        w_q[6] <= w_q[7]; w_q[7] <= w_q[8]; w_q[8] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_pix_q <= pix_i;
      s1_r1_q <= row_q == RW'(1);
      s1_c1_q <= col_q == CW'(1);
      s1_rge1_q <= row_q != '0;
      s1_cge1_q <= col_q != '0;
      s1_end_q <= endrow;
      s1_last_q <= lastrow;
    end
  end

  // window view after shifting in stage 1 pixel
  logic [PixW-1:0] v [9];
  always_comb begin
    v[0] = w_q[1]; v[1] = w_q[2]; v[2] = up_rd;
    v[3] = w_q[4]; v[4] = w_q[5]; v[5] = mid_rd;
    v[6] = w_q[7]; v[7] = w_q[8]; v[8] = s1_pix_q;
  end

  logic [1:0] t, m, b, l, c, r;
  always_comb begin
    t = s1_r1_q ? 2'd2 : 2'd0; m = 2'd1; b = 2'd2;
    if (cur[0]) begin t = 2'd1; m = 2'd2; b = 2'd1; end
    if (cur[1]) begin l = 2'd1; c = 2'd2; r = 2'd1; end
    else begin l = s1_c1_q ? 2'd2 : 2'd0; c = 2'd1; r = 2'd2; end
    job_o.tl = v[4'(t) * 4'd3 + 4'(l)]; job_o.tc = v[4'(t) * 4'd3 + 4'(c)];
    job_o.tr = v[4'(t) * 4'd3 + 4'(r)];
    job_o.ml = v[4'(m) * 4'd3 + 4'(l)]; job_o.mr = v[4'(m) * 4'd3 + 4'(r)];
    job_o.bl = v[4'(b) * 4'd3 + 4'(l)]; job_o.bc = v[4'(b) * 4'd3 + 4'(c)];
    job_o.br = v[4'(b) * 4'd3 + 4'(r)];
    job_o.run_end = !more;
    job_o.frame_end = !more && s1_last_q && s1_end_q;
  end
  assign job_valid_o = any && q_room_i;
endmodule

// File: sv/gef_queue.sv
// Two-entry job queue between front and back.
module gef_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gef_pkg::job_t data_i,
  output logic          room_o,
  output logic          valid_o,
  output gef_pkg::job_t data_o,
  input  logic          pop_i
);
  import gef_pkg::*;
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  assign room_o  = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];
  always_ff @(posedge clk_i) if (push_i) mem_q[wp_q] <= data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// File: sv/gef_back.sv
// Back part: gradient, magnitude, rounding and output register.
module gef_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  gef_pkg::job_t           job_i,
  output logic                    pop_o,
  input  logic [gef_pkg::SwW-1:0] weight_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [23:0]             pix_o,
  output logic                    run_end_o,
  output logic                    frame_end_o
);
  import gef_pkg::*;
  logic       adv;
  logic [7:0] res [3];
  assign adv   = !valid_o || !stall_i;
  assign pop_o = valid_i && adv;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [14:0] gx, gy, ax, ay;
      logic [15:0] s;
      logic [14:0] h;
      gx = 15'(signed'({1'b0, job_i.tr[8*ch +: 8]})) - 15'(signed'({1'b0, job_i.tl[8*ch +: 8]}))
         + signed'({1'b0, weight_i}) * (15'(signed'({1'b0, job_i.mr[8*ch +: 8]}))
         - 15'(signed'({1'b0, job_i.ml[8*ch +: 8]})))
         + 15'(signed'({1'b0, job_i.br[8*ch +: 8]})) - 15'(signed'({1'b0, job_i.bl[8*ch +: 8]}));
      gy = 15'(signed'({1'b0, job_i.bl[8*ch +: 8]})) - 15'(signed'({1'b0, job_i.tl[8*ch +: 8]}))
         + signed'({1'b0, weight_i}) * (15'(signed'({1'b0, job_i.bc[8*ch +: 8]}))
         - 15'(signed'({1'b0, job_i.tc[8*ch +: 8]})))
         + 15'(signed'({1'b0, job_i.br[8*ch +: 8]})) - 15'(signed'({1'b0, job_i.tr[8*ch +: 8]}));
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      s = 16'(unsigned'(ax)) + 16'(unsigned'(ay));
      h = s[15:1] + 15'(s[0] & s[1]);
      res[ch] = h > 15'd255 ? 8'd255 : h[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pix_o <= {res[2], res[1], res[0]};
      run_end_o <= job_i.run_end;
      frame_end_o <= job_i.frame_end;
    end
  end
endmodule

// File: sv/glowing_edge_filter_3x3_unit.sv
// Top level of the 3x3 glowing edge filter.
// Accepts one BGR pixel per clock in raster order and returns the gradient
// magnitude (|gx|+|gy|)/2 per channel, one row and one column behind; a
// result passes the stage 1 registers, the job queue and the output register.
// Row 0 and column 0 pixels produce nothing. The row-end pixel of every
// other row produces two results, each pixel of the last row past column 0
// produces two (four at the row end), and the job issue stalls input while
// it issues an extra result or the job queue is full; otherwise one pixel per
// clock is sustained, with the line stores read and written at one address in
// the front part.
module glowing_edge_filter_3x3_unit #(
  parameter int unsigned MaxWidth  = gef_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = gef_pkg::MaxHeightDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [7:0]               blue_in_i,
  input  logic [7:0]               green_in_i,
  input  logic [7:0]               red_in_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [7:0]               blue_out_o,
  output logic [7:0]               green_out_o,
  output logic [7:0]               red_out_o,
  output logic                     run_end_o,
  output logic                     frame_end_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [gef_pkg::CfgW-1:0] cfg_data_i
);
  import gef_pkg::*;
  logic [FwW-1:0] fw_q;
  logic [FhW-1:0] fh_q;
  logic [SwW-1:0] sw_q;
  logic jv, room, qv, pop;
  job_t jf, jq;
  logic [23:0] po;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FwW'(1920); fh_q <= FhW'(1080); sw_q <= SwW'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWidth:  fw_q <= cfg_data_i[FwW-1:0];
        RegHeight: fh_q <= cfg_data_i[FhW-1:0];
        RegWeight: sw_q <= cfg_data_i[SwW-1:0];
        default: ;
      endcase
    end
  end

  gef_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .pix_i({red_in_i, green_in_i, blue_in_i}),
    .frame_width_i(fw_q), .frame_height_i(fh_q),
    .job_valid_o(jv), .job_o(jf), .q_room_i(room)
  );
  gef_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .data_i(jf), .room_o(room),
    .valid_o(qv), .data_o(jq), .pop_i(pop)
  );
  gef_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .job_i(jq), .pop_o(pop), .weight_i(sw_q),
    .valid_o, .stall_i, .pix_o(po), .run_end_o, .frame_end_o
  );
  assign blue_out_o  = po[7:0];
  assign green_out_o = po[15:8];
  assign red_out_o   = po[23:16];
endmodule

// File: bench/glowing_edge_filter_3x3_unit_test.sv
// Self-checking testbench for the 3x3 glowing edge filter with a built-in predictor.
module glowing_edge_filter_3x3_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gef_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 24;

  typedef struct packed {
    logic [7:0] blue, green, red;
    logic       run_end, frame_end;
  } edge_beat_t;

  typedef struct packed {
    logic [7:0] blue, green, red;
    logic       typed;
    logic [7:0] level;
  } pixel_row_t;

  logic clk_i, rst_ni;
  logic valid_i, stall_o, valid_o, stall_i;
  logic [7:0] blue_in_i, green_in_i, red_in_i;
  logic [7:0] blue_out_o, green_out_o, red_out_o;
  logic run_end_o, frame_end_o;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  glowing_edge_filter_3x3_unit i_dut (.*);

  edge_beat_t edge_q[$];
  int unsigned cycles = 0;
  int unsigned errors = 0;
  bit calm = 0;

  // predictor state
  logic [PixW-1:0] upper_row [MaxWidthDef];
  logic [PixW-1:0] middle_row [MaxWidthDef];
  logic [PixW-1:0] win [9];
  int unsigned col_pos, row_pos;
  int unsigned width_reg, height_reg, weight_reg;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i <= 1'b1;
    end else begin
      stall_i <= !calm && ($urandom_range(99) < 37);
    end
  end

  function automatic int tap(int idx, int ch);
    return int'(win[idx % 9][8*ch +: 8]);
  endfunction

  function automatic edge_beat_t magnitude(int t, int m, int b, int l, int c, int r);
    edge_beat_t res;
    int gx, gy, s, h, w;
    w = int'(weight_reg);
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      gx = (tap(t*3+r, ch) - tap(t*3+l, ch)) + w * (tap(m*3+r, ch) - tap(m*3+l, ch))
         + (tap(b*3+r, ch) - tap(b*3+l, ch));
      gy = (tap(b*3+l, ch) - tap(t*3+l, ch)) + w * (tap(b*3+c, ch) - tap(t*3+c, ch))
         + (tap(b*3+r, ch) - tap(t*3+r, ch));
      s = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      h = s >> 1;
      if ((s & 1) && (h & 1)) h++;
      if (h > 255) h = 255;
      case (ch)
        0: res.blue = h[7:0];
        1: res.green = h[7:0];
        default: res.red = h[7:0];
      endcase
    end
    return res;
  endfunction

  task automatic predict_edges(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned wd, ht, c, rw, top, lft, n;
    bit endrow, lastrow;
    logic [PixW-1:0] px;
    wd = width_reg < 2 ? 2 : (width_reg > MaxWidthDef ? MaxWidthDef : width_reg);
    ht = height_reg < 2 ? 2 : (height_reg > MaxHeightDef ? MaxHeightDef : height_reg);
    c = col_pos % MaxWidthDef;
    rw = row_pos;
    px = {r, g, b};
    endrow = c >= wd - 1;
    lastrow = rw >= ht - 1;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = upper_row[c];
    win[5] = middle_row[c];
    win[8] = px;
    upper_row[c] = middle_row[c];
    middle_row[c] = px;
    top = (rw == 1) ? 2 : 0;
    if (rw >= 1 && c >= 1) begin
      lft = (c == 1) ? 2 : 0;
      edge_q.push_back(magnitude(top, 1, 2, lft, 1, 2));
      n++;
      if (lastrow) begin
        edge_q.push_back(magnitude(1, 2, 1, lft, 1, 2));
        n++;
      end
    end
    if (rw >= 1 && endrow) begin
      edge_q.push_back(magnitude(top, 1, 2, 1, 2, 1));
      n++;
      if (lastrow) begin
        edge_q.push_back(magnitude(1, 2, 1, 1, 2, 1));
        n++;
      end
    end
    if (n > 0) begin
      edge_q[$].run_end = 1'b1;
      edge_q[$].frame_end = lastrow && endrow;
    end
    if (endrow) begin
      col_pos = 0;
      row_pos = lastrow ? 0 : rw + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(negedge clk_i) begin
    edge_beat_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (edge_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        want = edge_q.pop_front();
        if (blue_out_o !== want.blue) begin
          $error("blue_out expected %0d got %0d", want.blue, blue_out_o);
          errors++;
        end
        if (green_out_o !== want.green) begin
          $error("green_out expected %0d got %0d", want.green, green_out_o);
          errors++;
        end
        if (red_out_o !== want.red) begin
          $error("red_out expected %0d got %0d", want.red, red_out_o);
          errors++;
        end
        if (run_end_o !== want.run_end) begin
          $error("run_end expected %0d got %0d", want.run_end, run_end_o);
          errors++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end expected %0d got %0d", want.frame_end, frame_end_o);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_sizes(int unsigned wd, int unsigned ht, int unsigned wt);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= RegWidth;
    cfg_data_i <= CfgW'(wd);
    @(posedge clk_i);
    cfg_index_i <= RegHeight;
    cfg_data_i <= CfgW'(ht);
    @(posedge clk_i);
    cfg_index_i <= RegWeight;
    cfg_data_i <= CfgW'(wt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = wd & 12'hFFF;
    height_reg = ht & 13'h1FFF;
    weight_reg = wt & 4'hF;
  endtask

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    bit taken;
    while (!calm && $urandom_range(99) < 37) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    blue_in_i <= b;
    green_in_i <= g;
    red_in_i <= r;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !stall_o;
      @(posedge clk_i);
    end
    predict_edges(b, g, r);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(int unsigned wd, int unsigned ht, int unsigned wt);
    int unsigned npix;
    write_sizes(wd, ht, wt);
    wd = width_reg < 2 ? 2 : (width_reg > MaxWidthDef ? MaxWidthDef : width_reg);
    ht = height_reg < 2 ? 2 : (height_reg > MaxHeightDef ? MaxHeightDef : height_reg);
    npix = wd * ht;
    for (int unsigned i = 0; i < npix; i++) send_pixel(rand_level(), rand_level(), rand_level());
    valid_i <= 1'b0;
  endtask

  pixel_row_t directed [17] = '{
    '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00},
    '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00},
    '{8'h00, 8'hFF, 8'h00, 1'b0, 8'h00}, '{8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00},
    '{8'h00, 8'hFF, 8'h00, 1'b0, 8'h00}, '{8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00},
    '{8'h00, 8'hFF, 8'h00, 1'b0, 8'h00}, '{8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00},
    '{8'h00, 8'hFF, 8'h00, 1'b0, 8'h00}, '{8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00},
    '{8'h00, 8'hFF, 8'h00, 1'b0, 8'h00},
    '{8'h00, 8'h00, 8'h00, 1'b0, 8'h00}, '{8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00},
    '{8'h80, 8'h01, 8'h7F, 1'b0, 8'h00}, '{8'hFE, 8'h55, 8'hAA, 1'b0, 8'h00}
  };

  initial begin
    int unsigned sent, mark;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    blue_in_i = '0;
    green_in_i = '0;
    red_in_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegWidth;
    cfg_data_i = '0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < MaxWidthDef; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    width_reg = 1920;
    height_reg = 1080;
    weight_reg = 3;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 17; i++) begin
      if (i == 4 || i == 13) valid_i <= 1'b0;
      if (i == 0) write_sizes(2, 2, 15);
      if (i == 4) write_sizes(3, 3, 0);
      if (i == 13) write_sizes(0, 1, 7);
      mark = edge_q.size();
      send_pixel(directed[i].blue, directed[i].green, directed[i].red);
      if (directed[i].typed) begin
        for (int k = mark; k < edge_q.size(); k++) begin
          edge_q[k].blue = directed[i].level;
          edge_q[k].green = directed[i].level;
          edge_q[k].red = directed[i].level;
        end
      end
    end
    valid_i <= 1'b0;

    sent = 0;
    for (int f = 0; sent < 210; f++) begin
      int unsigned wd, ht;
      calm = (f >= 3 && f < 7);
      wd = $urandom_range(2, 9);
      ht = $urandom_range(2, 6);
      send_frame(wd, ht, $urandom_range(15));
      sent += wd * ht;
    end
    calm = 0;
    send_frame(5, 4, 3);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
